// ----- design/lattice_spin_flip_sweep_macros.svh -----
// Assertion helpers for the lattice spin flip sweep
`ifndef LATTICE_SPIN_FLIP_SWEEP_MACROS_SVH
`define LATTICE_SPIN_FLIP_SWEEP_MACROS_SVH

// same-cycle implication, checked outside reset
`define LSFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LSFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/lsfs_pkg.sv -----
`default_nettype none

package lsfs_pkg;

   // lattice geometry
   localparam int MAX_SIDE    = 64;
   localparam int DIM_W       = 7;
   localparam int SITE_W      = 12;
   localparam int TOTAL_W     = 13;
   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;

   // spin store organised as words of 64 sites
   localparam int BIT_W       = 6;
   localparam int WORD_BITS   = 64;
   localparam int WORD_ADDR_W = SITE_W - BIT_W;
   localparam int STORE_WORDS = STORE_DEPTH / WORD_BITS;

   // flip decision: dice > count * 2^COUNT_SHIFT
   localparam int DICE_W      = 16;
   localparam int COUNT_W     = 3;
   localparam int COUNT_SHIFT = 14;

   // register map
   localparam int           CSR_INDEX_W = 1;
   localparam logic [0:0]   CSR_WIDTH   = 1'b0;
   localparam logic [0:0]   CSR_HEIGHT  = 1'b1;

   // commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // register value to effective side: 0 acts as 1, oversize saturates
   function automatic logic [DIM_W-1:0] clamp_side(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_SIDE)) begin
         r = DIM_W'(MAX_SIDE);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/lattice_spin_flip_sweep.sv -----
// Channel   Direction  Transaction carries
// req_*     in         command, spin_in, dice
// rsp_*     out        site_index, spin_out, sweep_end
// csr_*     in         register index and value, write only
//
// A load reads the centre word, an update five words: every site touched goes
// through the single read port of the spin store, one word read per cycle
// (four neighbours then the centre), followed by a write-back state.
// The first update after a width write also passes the shift-subtract
// unit that finds the column of the pointer. Reset is synchronous; the store
// needs no clearing pass, a row of word valid bits covers it. A stalled
// response holds the sequencer in write-back until it is taken.
`default_nettype none

module lattice_spin_flip_sweep (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_command,
   input  wire logic                            req_spin_in,
   input  wire logic [lsfs_pkg::DICE_W-1:0]     req_dice,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [lsfs_pkg::SITE_W-1:0]     rsp_site_index,
   output      logic                            rsp_spin_out,
   output      logic                            rsp_sweep_end,
   input  wire logic                            csr_we,
   input  wire logic [lsfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lsfs_pkg::DIM_W-1:0]      csr_wdata
);

   `include "lattice_spin_flip_sweep_macros.svh"

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_RD   = 2'd2;
   localparam logic [1:0] S_WB   = 2'd3;

   localparam logic [2:0] SEL_UP  = 3'd0;
   localparam logic [2:0] SEL_DN  = 3'd1;
   localparam logic [2:0] SEL_LF  = 3'd2;
   localparam logic [2:0] SEL_RT  = 3'd3;
   localparam logic [2:0] SEL_CTR = 3'd4;

   localparam int SW  = lsfs_pkg::SITE_W;
   localparam int DW  = lsfs_pkg::DIM_W;
   localparam int BW  = lsfs_pkg::BIT_W;
   localparam int DCW = lsfs_pkg::DICE_W;
   localparam int CW  = lsfs_pkg::COUNT_W;

   // registers
   logic [1:0]                         state_ff, state_in;
   logic [DW-1:0]                      width_ff, width_in;
   logic [DW-1:0]                      height_ff, height_in;
   logic [SW-1:0]                      ptr_ff, ptr_in;
   logic [BW-1:0]                      col_ff, col_in;
   logic                               stale_ff, stale_in;
   logic [SW-1:0]                      cur_p_ff, cur_p_in;
   logic                               cmd_ff, cmd_in;
   logic                               spin_ff, spin_in;
   logic [DCW-1:0]                     dice_ff, dice_in;
   logic [3:0]                         div_cnt_ff, div_cnt_in;
   logic [BW-1:0]                      rem_ff, rem_in;
   logic [2:0]                         sel_ff, sel_in;
   logic [BW-1:0]                      prev_bit_ff, prev_bit_in;
   logic [3:0]                         nb_ff, nb_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                      rsp_site_ff, rsp_site_in;
   logic                               rsp_spin_ff, rsp_spin_in;
   logic                               rsp_end_ff, rsp_end_in;
   logic [lsfs_pkg::STORE_WORDS-1:0]   word_vld_ff;

   // spin store
   logic [lsfs_pkg::WORD_BITS-1:0]     store_mem [lsfs_pkg::STORE_WORDS];
   logic [lsfs_pkg::WORD_BITS-1:0]     mem_rd_ff;
   logic                               vld_rd_ff;

   // combinational
   logic [DW-1:0]                      w_eff;
   logic [DW-1:0]                      h_eff;
   logic [lsfs_pkg::TOTAL_W-1:0]       total;
   logic                               req_fire;
   logic                               p_out_range;
   logic [SW-1:0]                      p_eff;
   logic                               rd_en;
   logic [SW-1:0]                      rd_addr;
   logic [lsfs_pkg::WORD_BITS-1:0]     rd_word;
   logic                               rd_bit;
   logic [1:0]                         nb_idx;
   logic [DW-1:0]                      div_trial;
   logic                               has_up, has_dn, has_lf, has_rt;
   logic [CW-1:0]                      count;
   logic                               flip;
   logic                               new_spin;
   logic                               out_load;
   logic                               last;
   logic                               wr_en;
   logic [lsfs_pkg::WORD_BITS-1:0]     wr_word;
   logic [DW-1:0]                      col_next;

   // effective dimensions
   assign w_eff = lsfs_pkg::clamp_side(width_ff);
   assign h_eff = lsfs_pkg::clamp_side(height_ff);
   assign total = lsfs_pkg::TOTAL_W'(w_eff) * lsfs_pkg::TOTAL_W'(h_eff);

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign p_out_range = ({1'b0, ptr_ff} >= total);
   assign p_eff       = p_out_range ? '0 : ptr_ff;

   // read address for the neighbour being fetched
   always_comb begin
      unique case (sel_ff)
         SEL_UP:  rd_addr = cur_p_ff - SW'(w_eff);
         SEL_DN:  rd_addr = cur_p_ff + SW'(w_eff);
         SEL_LF:  rd_addr = cur_p_ff - SW'(1);
         SEL_RT:  rd_addr = cur_p_ff + SW'(1);
         default: rd_addr = cur_p_ff;
      endcase
   end

   assign rd_en   = (state_ff == S_RD);
   assign rd_word = vld_rd_ff ? mem_rd_ff : '0;
   assign rd_bit  = rd_word[prev_bit_ff];
   assign nb_idx  = 2'(sel_ff - 3'd1);

   // column search: one restoring step per cycle
   assign div_trial = {rem_ff, cur_p_ff[div_cnt_ff]};

   // boundary tests, open edges
   assign has_up = ({1'b0, cur_p_ff} >= {{(SW+1-DW){1'b0}}, w_eff});
   assign has_dn = (({1'b0, cur_p_ff} + (SW+1)'(w_eff)) < total);
   assign has_lf = (col_ff != '0);
   assign has_rt = ({1'b0, col_ff} != (w_eff - DW'(1)));

   assign count = CW'(nb_ff[0] & has_up) + CW'(nb_ff[1] & has_dn)
                + CW'(nb_ff[2] & has_lf) + CW'(nb_ff[3] & has_rt);
   assign flip  = ({1'b0, dice_ff} > {count, {lsfs_pkg::COUNT_SHIFT{1'b0}}});

   assign new_spin = (cmd_ff == lsfs_pkg::CMD_UPDATE) ? (rd_bit ^ flip) : spin_ff;
   assign out_load = (state_ff == S_WB) && (!rsp_valid_ff || rsp_ready);
   assign last     = (({1'b0, cur_p_ff} + (lsfs_pkg::TOTAL_W)'(1)) == total);
   assign wr_en    = out_load;
   assign col_next = {1'b0, col_ff} + DW'(1);

   always_comb begin
      wr_word              = rd_word;
      wr_word[prev_bit_ff] = new_spin;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      ptr_in       = ptr_ff;
      col_in       = col_ff;
      stale_in     = stale_ff;
      cur_p_in     = cur_p_ff;
      cmd_in       = cmd_ff;
      spin_in      = spin_ff;
      dice_in      = dice_ff;
      div_cnt_in   = div_cnt_ff;
      rem_in       = rem_ff;
      sel_in       = sel_ff;
      prev_bit_in  = prev_bit_ff;
      nb_in        = nb_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_site_in  = rsp_site_ff;
      rsp_spin_in  = rsp_spin_ff;
      rsp_end_in   = rsp_end_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes must only arrive while idle; the block does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            lsfs_pkg::CSR_WIDTH: begin
               width_in = csr_wdata;
               stale_in = 1'b1;
            end
            lsfs_pkg::CSR_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cur_p_in = p_eff;
               cmd_in   = req_command;
               spin_in  = req_spin_in;
               dice_in  = req_dice;
               if (p_out_range) begin
                  col_in   = '0;
                  stale_in = 1'b0;
               end
               sel_in = (req_command == lsfs_pkg::CMD_UPDATE) ? SEL_UP : SEL_CTR;
               if ((req_command == lsfs_pkg::CMD_UPDATE) && stale_ff && !p_out_range) begin
                  div_cnt_in = 4'(SW - 1);
                  rem_in     = '0;
                  state_in   = S_DIV;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_DIV: begin
            if (div_trial >= w_eff) begin
               rem_in = BW'(div_trial - w_eff);
            end else begin
               rem_in = BW'(div_trial);
            end
            if (div_cnt_ff == '0) begin
               col_in   = (div_trial >= w_eff) ? BW'(div_trial - w_eff) : BW'(div_trial);
               stale_in = 1'b0;
               state_in = S_RD;
            end else begin
               div_cnt_in = div_cnt_ff - 4'd1;
            end
         end
         S_RD: begin
            // issue this read, capture the previous neighbour
            prev_bit_in = rd_addr[BW-1:0];
            if ((cmd_ff == lsfs_pkg::CMD_UPDATE) && (sel_ff != SEL_UP)) begin
               nb_in[nb_idx] = rd_bit;
            end
            if (sel_ff == SEL_CTR) begin
               state_in = S_WB;
            end else begin
               sel_in = sel_ff + 3'd1;
            end
         end
         S_WB: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_site_in  = cur_p_ff;
               rsp_spin_in  = new_spin;
               rsp_end_in   = last;
               if (last) begin
                  ptr_in   = '0;
                  col_in   = '0;
                  stale_in = 1'b0;
               end else begin
                  ptr_in = cur_p_ff + SW'(1);
                  if (!stale_ff) begin
                     col_in = (col_next == w_eff) ? '0 : BW'(col_next);
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= DW'(lsfs_pkg::MAX_SIDE);
         height_ff    <= DW'(lsfs_pkg::MAX_SIDE);
         ptr_ff       <= '0;
         col_ff       <= '0;
         stale_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         word_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         ptr_ff       <= ptr_in;
         col_ff       <= col_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            word_vld_ff[cur_p_ff[SW-1:BW]] <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_p_ff    <= cur_p_in;
      cmd_ff      <= cmd_in;
      spin_ff     <= spin_in;
      dice_ff     <= dice_in;
      div_cnt_ff  <= div_cnt_in;
      rem_ff      <= rem_in;
      sel_ff      <= sel_in;
      prev_bit_ff <= prev_bit_in;
      nb_ff       <= nb_in;
      rsp_site_ff <= rsp_site_in;
      rsp_spin_ff <= rsp_spin_in;
      rsp_end_ff  <= rsp_end_in;
   end

   // spin store, one read and one write port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff <= store_mem[rd_addr[SW-1:BW]];
         vld_rd_ff <= word_vld_ff[rd_addr[SW-1:BW]];
      end
      if (wr_en) begin
         store_mem[cur_p_ff[SW-1:BW]] <= wr_word;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_site_index = rsp_site_ff;
   assign rsp_spin_out   = rsp_spin_ff;
   assign rsp_sweep_end  = rsp_end_ff;

   // checks
   `LSFS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready,
      "block still ready after accepting a transaction")
   `LSFS_ASSERT_NEXT(a_wrap_on_last, clock, reset, out_load && last, ptr_ff == '0,
      "pointer did not wrap after the last site")
   `LSFS_ASSERT_NOW(a_col_in_row, clock, reset, !stale_ff, {1'b0, col_ff} < w_eff,
      "column tracker outside the row")
   `LSFS_ASSERT_NOW(a_rsp_from_wb, clock, reset, $rose(rsp_valid), $past(state_ff == S_WB),
      "response raised outside write-back")

endmodule

`default_nettype wire
